>>> sv/bbr_pkg.sv
// Shared types, constants and helpers for the 3x3 RGB box blur.
// No dependencies; imported by every module of the block.
package bbr_pkg;

  // Parameter defaults and fixed field widths
  localparam int MAX_COLUMNS_DEF = 512;
  localparam int MAX_ROWS_DEF    = 512;
  localparam int DIM_W           = 10;    // frame_width / frame_height registers
  localparam int CH_W            = 8;     // one color channel
  localparam int NUM_CH          = 3;
  localparam int PIX_W           = NUM_CH * CH_W;
  localparam int SUM_W           = 12;    // 9 * 255 = 2295 fits
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [DIM_W-1:0] FRAME_DIM_RESET = DIM_W'(512);

  // Divide by nine: q = (s * 3641) >> 15, exact for s < 32768
  localparam logic [SUM_W-1:0] DIV9_MUL   = SUM_W'(3641);
  localparam int               DIV9_SHIFT = 15;

  // Input word kind, carried on tuser
  typedef enum logic [0:0] {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } reg_idx_e;

  // Per-item control decided by the front end
  typedef struct packed {
    logic rd_two;    // row two above lies inside the frame
    logic rd_one;    // row above lies inside the frame
    logic cur;       // current row inside the frame: line stores get written
    logic emit;      // this step delivers a result
    logic use_v;     // newest column joins the window
    logic use_prev2; // oldest column joins the window
    logic last;      // result is the frame's final pixel
  } ctl_t;

endpackage

>>> sv/bbr_fifo.sv
// Small flop-based queue between the front end and the back end.
// Depends on bbr_pkg for the default depth.
module bbr_fifo
  import bbr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/bbr_front.sv
// Front end: config registers, stream position tracking, word classification.
// Depends on bbr_pkg; feeds per-item descriptors into bbr_fifo.
module bbr_front
  import bbr_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  localparam int IDX_W      = $clog2(MAX_COLUMNS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output logic                 cfg_ready_o,
  output logic                 restart_o,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_action_i,
  input  logic [PIX_W-1:0]     in_pix_i,
  // queue side
  input  logic                 q_full_i,
  output logic                 push_o,
  output logic [IDX_W-1:0]     push_idx_o,
  output logic [PIX_W-1:0]     push_pix_o,
  output ctl_t                 push_ctl_o
);

  localparam int WW = $clog2(MAX_COLUMNS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int RW = $clog2(MAX_ROWS + 2);

  logic [DIM_W-1:0] width_q, width_d, height_q, height_d;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic [IDX_W-1:0] col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic             cfg_wr, cfg_hit, accept, cur, drop, col_wrap;
  ctl_t             ctl;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  // only writes to a known register restart the frame
  assign cfg_hit     = cfg_wr && ((reg_idx_e'(cfg_index_i) == REG_FRAME_WIDTH) ||
                                  (reg_idx_e'(cfg_index_i) == REG_FRAME_HEIGHT));
  assign restart_o   = cfg_hit;
  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;

  // register writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FRAME_WIDTH:  width_d  = cfg_data_i;
        REG_FRAME_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the registers to 1..MAX
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_q) > MAX_COLUMNS) begin
      eff_w = WW'(MAX_COLUMNS);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (int'(height_q) > MAX_ROWS) begin
      eff_h = HW'(MAX_ROWS);
    end else begin
      eff_h = HW'(height_q);
    end
  end

  // classify the word at the current stream position
  always_comb begin
    cur           = int'(row_q) < int'(eff_h);
    drop          = cur && (action_e'(in_action_i) == ACT_DRAIN);
    ctl.cur       = cur;
    ctl.rd_one    = (row_q != '0) && (int'(row_q) <= int'(eff_h));
    ctl.rd_two    = int'(row_q) >= 2;
    ctl.emit      = (int'(row_q) >= 2) || ((int'(row_q) == 1) && (col_q != '0));
    ctl.last      = ctl.emit && (int'(row_q) == int'(eff_h) + 1);
    ctl.use_v     = (col_q != '0);
    ctl.use_prev2 = (col_q != '0) ? (int'(col_q) >= 2) : (int'(eff_w) >= 2);
    col_wrap      = int'(col_q) == int'(eff_w) - 1;
  end

  assign push_o     = accept && !drop;
  assign push_idx_o = col_q;
  assign push_pix_o = cur ? in_pix_i : '0;
  assign push_ctl_o = ctl;

  // stream position, back to the top after the last result or a register write
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (push_o) begin
      if (ctl.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_DIM_RESET;
      height_q <= FRAME_DIM_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

>>> sv/bbr_back.sv
// Back end: two line stores, 3x3 window, channel sums, divide by nine, output register.
// Depends on bbr_pkg; pops descriptors from bbr_fifo.
module bbr_back
  import bbr_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  localparam int IDX_W      = $clog2(MAX_COLUMNS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  // queue side
  input  logic             q_valid_i,
  input  logic [IDX_W-1:0] q_idx_i,
  input  logic [PIX_W-1:0] q_pix_i,
  input  ctl_t             q_ctl_i,
  output logic             pop_o,
  // result words
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] out_data_o,
  output logic             out_last_o
);

  // line stores
  logic [PIX_W-1:0] above_mem [MAX_COLUMNS];
  logic [PIX_W-1:0] two_mem   [MAX_COLUMNS];

  // window stage
  logic             s2_v_q;
  logic [IDX_W-1:0] s2_idx_q;
  logic [PIX_W-1:0] s2_pix_q;
  ctl_t             s2_ctl_q;
  logic [PIX_W-1:0] rd_one_raw_q, rd_two_raw_q, fwd_one_q, fwd_two_q;
  logic             fwd_q, fwd;
  logic [PIX_W-1:0] eff_one, eff_two;
  logic [PIX_W-1:0] col_v [3];
  logic [PIX_W-1:0] wc0_q [3];
  logic [PIX_W-1:0] wc1_q [3];
  logic [SUM_W-1:0] sum_d [NUM_CH];

  // sum stage
  logic             s3_v_q;
  logic [SUM_W-1:0] sum_q [NUM_CH];
  logic             s3_last_q;

  // output register
  logic             out_v_q;
  logic [PIX_W-1:0] out_data_q, out_data_d;
  logic             out_last_q;

  logic out_free, s3_free, s3_adv, s2_adv, s2_wr, clear_win;

  // stage handshakes
  assign out_free  = !out_v_q || out_ready_i;
  assign s3_adv    = s3_v_q && out_free;
  assign s3_free   = !s3_v_q || out_free;
  assign s2_adv    = s2_v_q && s3_free;
  assign pop_o     = q_valid_i && (!s2_v_q || s2_adv);
  assign s2_wr     = s2_adv && s2_ctl_q.cur;
  assign clear_win = restart_i || (s2_adv && s2_ctl_q.last);

  // same column written by the retiring item as read by the popping one (width 1)
  assign fwd = s2_v_q && s2_ctl_q.cur && (s2_idx_q == q_idx_i);

  // line store read and write
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_one_raw_q <= above_mem[q_idx_i];
      rd_two_raw_q <= two_mem[q_idx_i];
    end
    if (s2_wr) begin
      above_mem[s2_idx_q] <= s2_pix_q;
      two_mem[s2_idx_q]   <= eff_one;
    end
  end

  // bypass data and window stage payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      fwd_one_q <= s2_pix_q;
      fwd_two_q <= eff_one;
      s2_idx_q  <= q_idx_i;
      s2_pix_q  <= q_pix_i;
      s2_ctl_q  <= q_ctl_i;
    end
  end

  assign eff_one  = fwd_q ? fwd_one_q : rd_one_raw_q;
  assign eff_two  = fwd_q ? fwd_two_q : rd_two_raw_q;
  assign col_v[0] = s2_ctl_q.rd_two ? eff_two : '0;
  assign col_v[1] = s2_ctl_q.rd_one ? eff_one : '0;
  assign col_v[2] = s2_pix_q;

  // per-channel window sums
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_d[c] = '0;
      for (int r = 0; r < 3; r++) begin
        sum_d[c] = sum_d[c] + SUM_W'(wc0_q[r][c*CH_W +: CH_W]);
        if (s2_ctl_q.use_v) begin
          sum_d[c] = sum_d[c] + SUM_W'(col_v[r][c*CH_W +: CH_W]);
        end
        if (s2_ctl_q.use_prev2) begin
          sum_d[c] = sum_d[c] + SUM_W'(wc1_q[r][c*CH_W +: CH_W]);
        end
      end
    end
  end

  // divide by nine via reciprocal multiply
  always_comb begin
    logic [2*SUM_W-1:0] prod;
    for (int c = 0; c < NUM_CH; c++) begin
      prod = sum_q[c] * DIV9_MUL;
      out_data_d[c*CH_W +: CH_W] = prod[DIV9_SHIFT +: CH_W];
    end
  end

  // window columns: shift on every retiring item, clear at frame end or on restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        wc0_q[r] <= '0;
        wc1_q[r] <= '0;
      end
    end else if (clear_win) begin
      for (int r = 0; r < 3; r++) begin
        wc0_q[r] <= '0;
        wc1_q[r] <= '0;
      end
    end else if (s2_adv) begin
      for (int r = 0; r < 3; r++) begin
        wc1_q[r] <= wc0_q[r];
        wc0_q[r] <= col_v[r];
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      fwd_q   <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s2_v_q <= 1'b1;
        fwd_q  <= fwd;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv && s2_ctl_q.emit) begin
        s3_v_q <= 1'b1;
      end else if (s3_adv) begin
        s3_v_q <= 1'b0;
      end
      if (s3_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // sum and output payload
  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_ctl_q.emit) begin
      sum_q     <= sum_d;
      s3_last_q <= s2_ctl_q.last;
    end
    if (s3_adv) begin
      out_data_q <= out_data_d;
      out_last_q <= s3_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

>>> sv/box_blur_3x3_rgb_unit.sv
// Top level of the 3x3 RGB box blur: front end, descriptor queue, back end.
// Depends on bbr_pkg, bbr_front, bbr_fifo and bbr_back.
//
// Pixels enter in raster order, one word per cycle while tready is high; each
// frame pixel comes out as its 3x3 neighborhood sum per channel divided by nine
// (truncated, outside pixels count as zero), in raster order, one row plus one
// pixel of stream behind the input. After the frame's pixels, drain words
// (tuser = 1) push out the remaining results; drain words sent mid-frame are
// swallowed, and pixels sent after the frame's last pixel act as drains. The last
// result of a frame carries tlast. Sustained rate is one word per cycle while the
// result side keeps up, set by the line stores, which take one read and one write
// per word; the result a word releases passes through the queue, the window stage,
// the sum stage and the output register. Writing frame_width (index 0) or
// frame_height (index 1) restarts the frame and must only be done while the block
// is idle; writes to other indexes are ignored; values are clamped to 1..MAX.
module box_blur_3x3_rgb_unit
  import bbr_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [PIX_W-1:0]     s_axis_tdata_i,   // red_in, green_in, blue_in
  input  logic [0:0]           s_axis_tuser_i,   // action
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [PIX_W-1:0]     m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic                 m_axis_tlast_o    // frame_last
);

  localparam int IDX_W = $clog2(MAX_COLUMNS);
  localparam int Q_W   = IDX_W + PIX_W + $bits(ctl_t);

  logic             restart, q_full, push, pop, q_valid;
  logic [IDX_W-1:0] push_idx, q_idx;
  logic [PIX_W-1:0] push_pix, q_pix;
  ctl_t             push_ctl, q_ctl;
  logic [Q_W-1:0]   q_head;

  bbr_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .restart_o   (restart),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i[0]),
    .in_pix_i    (s_axis_tdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_idx_o  (push_idx),
    .push_pix_o  (push_pix),
    .push_ctl_o  (push_ctl)
  );

  bbr_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_idx, push_pix, push_ctl}),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  assign {q_idx, q_pix, q_ctl} = q_head;

  bbr_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .q_valid_i   (q_valid),
    .q_idx_i     (q_idx),
    .q_pix_i     (q_pix),
    .q_ctl_i     (q_ctl),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

>>> sv/bbr_checker.sv
// Port-level checks for the box blur top level, attached by bind.
// Depends on bbr_pkg for widths.
module bbr_checker
  import bbr_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [PIX_W-1:0]     m_axis_tdata_o,
  input logic                 m_axis_tlast_o
);

  logic quiet;

  // no word taken in while the result side keeps draining
  assign quiet = !(s_axis_tvalid_i && s_axis_tready_o) && m_axis_tready_i;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result word changed while stalled");

  // the queue only fills by accepting words, so ready cannot drop on its own
  a_ready_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && !s_axis_tvalid_i |=> s_axis_tready_o)
    else $error("input ready dropped without an accepted word");

  // pipeline empties when quiet persists
  a_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quiet ##1 quiet ##1 quiet ##1 quiet ##1 quiet ##1 quiet |=> !m_axis_tvalid_o)
    else $error("result appeared with nothing in flight");

endmodule

bind box_blur_3x3_rgb_unit bbr_checker u_bbr_checker (.*);

>>> test/tb_box_blur_3x3_rgb_unit.sv
// Self-checking testbench for box_blur_3x3_rgb_unit: streams RGB frames with random stalls
// and compares every blurred word against an in-bench blur predictor.
// Depends on bbr_pkg and box_blur_3x3_rgb_unit.
module tb_box_blur_3x3_rgb_unit;
  import bbr_pkg::*;

  localparam int unsigned WINDOW_TAPS = 9;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_TARGET = 1200;
  localparam int unsigned CALM_AFTER = 1100;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TALL_ROWS = 48;

  // indexes past the register list, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    action_e         action;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } px_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } blur_px_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DIM_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [PIX_W-1:0]     s_axis_tdata_i = '0;   // red_in, green_in, blue_in
  logic [0:0]           s_axis_tuser_i = '0;   // action
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [PIX_W-1:0]     m_axis_tdata_o;        // red_out, green_out, blue_out
  logic                 m_axis_tlast_o;        // frame_last

  box_blur_3x3_rgb_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and expectation stores
  px_word_t pixel_words_q[$];
  blur_px_t blurred_q[$];
  int unsigned item_count = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit idle_en = 1'b1;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;

  // Blur predictor state
  logic [DIM_W-1:0]      width_reg = FRAME_DIM_RESET;
  logic [DIM_W-1:0]      height_reg = FRAME_DIM_RESET;
  logic [PIX_W-1:0]      line_above [MAX_COLUMNS_DEF];
  logic [PIX_W-1:0]      line_two_above [MAX_COLUMNS_DEF];
  logic [2:0][PIX_W-1:0] win_new = '0;   // newest column, rows top to bottom
  logic [2:0][PIX_W-1:0] win_old = '0;   // column before it
  int unsigned in_row = 0, in_col = 0, out_row = 0, out_col = 0;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned col_sum(input logic [2:0][PIX_W-1:0] c, input int ch);
    return 32'(c[0][ch*CH_W +: CH_W]) + 32'(c[1][ch*CH_W +: CH_W]) +
           32'(c[2][ch*CH_W +: CH_W]);
  endfunction

  function automatic void restart_stream();
    win_new = '0;
    win_old = '0;
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  function automatic void blur_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else if (idx == REG_FRAME_HEIGHT) height_reg = val;
    else return;
    restart_stream();
  endfunction

  // Advance the predictor by one accepted word; queue the blurred pixel it releases
  function automatic void blur_step(input px_word_t wd);
    int unsigned w, h, ir, ic, idx;
    logic [PIX_W-1:0] pix;
    logic [2:0][PIX_W-1:0] col;
    int unsigned acc [3];
    bit emit;
    blur_px_t res;
    w = clamp_dim(width_reg, MAX_COLUMNS_DEF);
    h = clamp_dim(height_reg, MAX_ROWS_DEF);
    ir = in_row;
    ic = in_col;
    pix = '0;
    idx = ic % MAX_COLUMNS_DEF;
    if (ir < h) begin
      // drains inside the frame are swallowed
      if (wd.action == ACT_DRAIN) return;
      pix = {wd.blue, wd.green, wd.red};
    end
    col[0] = (ir >= 2 && ir - 2 < h) ? line_two_above[idx] : '0;
    col[1] = (ir >= 1 && ir - 1 < h) ? line_above[idx] : '0;
    col[2] = (ir < h) ? pix : '0;
    if (ir < h) begin
      line_two_above[idx] = line_above[idx];
      line_above[idx] = pix;
    end
    emit = (ir >= 2) || (ir == 1 && ic >= 1);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (ic >= 1)
        acc[ch] = col_sum(col, ch) + col_sum(win_new, ch) + ((ic >= 2) ? col_sum(win_old, ch) : 0);
      else
        acc[ch] = col_sum(win_new, ch) + ((w >= 2) ? col_sum(win_old, ch) : 0);
    end
    win_old = win_new;
    win_new = col;
    ic++;
    if (ic >= w) begin
      ic = 0;
      ir++;
    end
    in_row = ir;
    in_col = ic;
    if (!emit) return;
    res.red = CH_W'(acc[0] / WINDOW_TAPS);
    res.green = CH_W'(acc[1] / WINDOW_TAPS);
    res.blue = CH_W'(acc[2] / WINDOW_TAPS);
    res.last = (out_row == h - 1) && (out_col == w - 1);
    blurred_q.push_back(res);
    if (res.last) begin
      restart_stream();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  // Input driver: offers the queue head, holds it until taken, idles in bursts
  bit holding;
  int unsigned src_gap = 0;
  px_word_t head;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) blur_step(pixel_words_q.pop_front());
      holding = s_axis_tvalid_i && !s_axis_tready_o;
      if (!holding) begin
        if (src_gap != 0) src_gap--;
        else if (idle_en && pixel_words_q.size() != 0 && $urandom_range(0, 9) == 0)
          src_gap = $urandom_range(1, 16);
      end
      if (holding || (src_gap == 0 && pixel_words_q.size() != 0)) begin
        head = pixel_words_q[0];
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {head.blue, head.green, head.red};
        s_axis_tuser_i <= head.action;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result-side ready: long holds on request, random bursts otherwise
  int unsigned hold_left = 0;
  int unsigned sink_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (holds_done != hold_reqs) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      m_axis_tready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(1, 16) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Result monitor: compare each word with the oldest prediction
  blur_px_t exp_px;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (blurred_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected word: r=%h g=%h b=%h last=%b", m_axis_tdata_o[7:0],
                   m_axis_tdata_o[15:8], m_axis_tdata_o[23:16], m_axis_tlast_o);
      end else begin
        exp_px = blurred_q.pop_front();
        if (m_axis_tdata_o[7:0] !== exp_px.red || m_axis_tdata_o[15:8] !== exp_px.green ||
            m_axis_tdata_o[23:16] !== exp_px.blue || m_axis_tlast_o !== exp_px.last) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("mismatch: exp r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
                     exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                     m_axis_tdata_o[7:0], m_axis_tdata_o[15:8], m_axis_tdata_o[23:16],
                     m_axis_tlast_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** box_blur_3x3_rgb_unit: FAILED **");
      $finish;
    end
  end

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_words_q.push_back('{action: ACT_PIXEL, red: r, green: g, blue: b});
    item_count++;
  endtask

  task automatic push_drain();
    pixel_words_q.push_back('{action: ACT_DRAIN, red: CH_W'($urandom),
                              green: CH_W'($urandom), blue: CH_W'($urandom)});
    item_count++;
  endtask

  task automatic wait_drained();
    while (pixel_words_q.size() != 0 || s_axis_tvalid_i || blurred_q.size() != 0)
      @(posedge clk_i);
  endtask

  // idle: nothing queued, nothing expected, pipeline given time to settle
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    blur_cfg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // One frame of random pixels with stray drains, then a tail of drains
  // and late pixels; a cut frame stops early and waits for a restart
  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit cut,
                             input int pause_at);
    int unsigned npix;
    npix = (cut && w * h > 1) ? $urandom_range(1, w * h - 1) : w * h;
    for (int k = 0; k < npix; k++) begin
      if (k == pause_at) wait_drained();
      if ($urandom_range(0, 15) == 0) push_drain();
      push_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    end
    if (npix < w * h) return;
    for (int t = 0; t <= w; t++) begin
      if ($urandom_range(0, 3) == 0) push_pixel(CH_W'($urandom), CH_W'($urandom),
                                                CH_W'($urandom));
      else push_drain();
    end
    if ($urandom_range(0, 7) == 0) push_drain();
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] wv, hv;
    int nfr;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 3x3 frame with channel extremes, stray drain, late pixel
    cfg_write(REG_SPARE_3, 10'h3ff);
    cfg_write(REG_FRAME_WIDTH, 10'd3);
    cfg_write(REG_FRAME_HEIGHT, 10'd3);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hff, 8'hff, 8'hff);
    push_pixel(8'hff, 8'h00, 8'h00);
    push_drain();
    push_pixel(8'h00, 8'hff, 8'h00);
    // out-of-range index written mid-frame must not restart
    wait_idle();
    cfg_write(REG_SPARE_2, 10'h155);
    push_pixel(8'h00, 8'h00, 8'hff);
    push_pixel(8'hff, 8'hff, 8'hff);
    push_pixel(8'h80, 8'h40, 8'h01);
    push_pixel(8'hff, 8'hff, 8'hff);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hff, 8'hff, 8'hff);
    push_drain();
    push_drain();
    push_drain();
    push_drain();
    // partial frame dropped by a register write; zero sizes clamp to 1x1
    push_pixel(8'hff, 8'hff, 8'hff);
    push_pixel(8'hff, 8'hff, 8'hff);
    push_pixel(8'hff, 8'hff, 8'hff);
    wait_idle();
    cfg_write(REG_FRAME_WIDTH, 10'd0);
    cfg_write(REG_FRAME_HEIGHT, 10'd0);
    push_pixel(8'hff, 8'hff, 8'hff);
    push_drain();
    push_drain();

    // widest frame, one row
    wait_idle();
    cfg_write(REG_FRAME_WIDTH, 10'h3ff);
    cfg_write(REG_FRAME_HEIGHT, 10'd1);
    queue_frame(MAX_COLUMNS_DEF, 1, 1'b0, -1);

    // one-column frame; output held off while input keeps coming,
    // then the sender pauses midway until all results are in
    wait_idle();
    cfg_write(REG_FRAME_WIDTH, 10'd1);
    cfg_write(REG_FRAME_HEIGHT, DIM_W'(TALL_ROWS));
    hold_reqs++;
    queue_frame(1, TALL_ROWS, 1'b0, int'(TALL_ROWS / 2));

    // random sizes, mostly small
    while (item_count < ITEM_TARGET) begin
      wait_idle();
      if (item_count > CALM_AFTER) idle_en = 1'b0;
      wv = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 40)) :
                                         DIM_W'($urandom_range(1, 8));
      hv = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 20)) :
                                         DIM_W'($urandom_range(1, 6));
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(REG_FRAME_HEIGHT, hv);
        cfg_write(REG_FRAME_WIDTH, wv);
      end else begin
        cfg_write(REG_FRAME_WIDTH, wv);
        cfg_write(REG_FRAME_HEIGHT, hv);
      end
      nfr = $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++)
        queue_frame(clamp_dim(wv, MAX_COLUMNS_DEF), clamp_dim(hv, MAX_ROWS_DEF),
                    (f == nfr - 1) && ($urandom_range(0, 9) == 0), -1);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && blurred_q.size() == 0) begin
      $display("** box_blur_3x3_rgb_unit: PASSED **");
    end else begin
      $display("** box_blur_3x3_rgb_unit: FAILED **");
    end
    $finish;
  end

endmodule
